FILE: hw/rtl/gcoh_pkg.sv
// Shared types and constants of the grid cell occupancy histogram.
package gcoh_pkg;

    localparam int KIND_W     = 2;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int IDX_W      = 6;
    localparam int USE_W      = 7;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS  = SIZE_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 3'd5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD        = 2'd0,
        KIND_SAMPLE_ALL = 2'd1,
        KIND_SAMPLE_PT  = 2'd2,
        KIND_READ       = 2'd3
    } t_kind;

    typedef struct packed {
        logic              neg;
        logic [SIZE_W-1:0] quot;
        logic              rem_nz;
    } t_div_res;

endpackage

FILE: hw/rtl/gcoh_ram.sv
// Generic single-port-write, registered-read RAM.
module gcoh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/gcoh_div.sv
// Radix-4 restoring divider that bins one axis coordinate.
module gcoh_div
    import gcoh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIFF_W-1:0] i_diff,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output t_div_res          o_res
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SIZE_W-1:0] r_dvd;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic              r_neg;

    logic [SIZE_W:0]   s1;
    logic [SIZE_W:0]   s2;
    logic              q1;
    logic              q2;
    logic [SIZE_W-1:0] rem1;
    logic [SIZE_W-1:0] rem2;

    always_comb begin
        s1   = {r_rem, r_dvd[SIZE_W-1]};
        q1   = (s1 >= {1'b0, r_div});
        rem1 = q1 ? SIZE_W'(s1 - {1'b0, r_div}) : SIZE_W'(s1);
        s2   = {rem1, r_dvd[SIZE_W-2]};
        q2   = (s2 >= {1'b0, r_div});
        rem2 = q2 ? SIZE_W'(s2 - {1'b0, r_div}) : SIZE_W'(s2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_dvd  <= i_diff[SIZE_W-1:0];
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_diff[DIFF_W-1];
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[SIZE_W-3:0], q1, q2};
                r_rem  <= rem2;
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = '{neg: r_neg, quot: r_dvd, rem_nz: (r_rem != '0)};

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still iterating");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_step == LAST_STEP |=> r_done)
        else $error("divider missed its done pulse");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_div)
        else $error("divider remainder not below divisor");

endmodule

FILE: hw/rtl/grid_cell_occupancy_histogram_top.sv
// Top level of the grid cell occupancy histogram.
//
// Input channel (i_in_valid / o_in_stall) takes one command beat: add an
// object at a point, raise the sample count of all cells, raise the sample
// count of the cell at a point, or read one cell. Every beat yields exactly
// one result beat on the output channel (o_out_valid / i_out_stall).
// Configuration (i_cfg_valid / o_cfg_ready, index and data) is always ready.
//
// Steps per beat, in order: for points inside the grid, start, 8 divider
// steps of two quotient bits each, done, memory read, update, sample sum,
// emit; for points outside it, memory read, update and sample sum are
// skipped; cell reads in range go straight to memory read; reads out of
// range and sample-all go straight to emit. One beat is in work at a time;
// the result lands in an output register, and the next beat is taken while it waits.
//
// After reset both count memories are cleared, one entry per cycle, all
// MAX_COLUMNS * MAX_ROWS entries (4096 by default), with o_in_stall high.
// A stalled result holds in the output register; once the block finishes
// the next beat it waits until that register drains.
module grid_cell_occupancy_histogram_top
    import gcoh_pkg::*;
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int COUNT_BITS  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic [IDX_W-1:0]          i_read_column,
    input  logic [IDX_W-1:0]          i_read_row,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_inside_res,
    output logic [IDX_W-1:0]          o_cell_column,
    output logic [IDX_W-1:0]          o_cell_row,
    output logic [OUT_W-1:0]          o_object_total,
    output logic [OUT_W-1:0]          o_sample_total
);

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAX_CR = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int NW_RAW = $clog2(MAX_CR + 1);
    localparam int NW     = (NW_RAW > USE_W) ? NW_RAW : USE_W;

    localparam logic [NW-1:0]         NCOL_MAX   = NW'(MAX_COLUMNS);
    localparam logic [NW-1:0]         NROW_MAX   = NW'(MAX_ROWS);
    localparam logic [AW:0]           ROW_STRIDE = (AW + 1)'(MAX_ROWS);
    localparam logic [AW-1:0]         LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_RMW,
        S_SUM,
        S_EMIT
    } t_state;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [NW-1:0] clamp_n(input logic [USE_W-1:0] u,
                                              input logic [NW-1:0] mx);
        logic [NW-1:0] e;
        e = NW'(u);
        if (e == '0) begin
            return NW'(1);
        end
        return (e > mx) ? mx : e;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                input logic [ROW_W-1:0] row);
        logic [AW:0] a;
        a = (AW + 1)'(col) * ROW_STRIDE + (AW + 1)'(row);
        return a[AW-1:0];
    endfunction

    function automatic logic axis_in(input t_div_res r, input logic [NW-1:0] n);
        logic [SIZE_W:0] q;
        logic [SIZE_W:0] nn;
        q  = {1'b0, r.quot};
        nn = (SIZE_W + 1)'(n);
        return !r.neg && ((q < nn) || ((q == nn) && !r.rem_nz));
    endfunction

    function automatic logic [SIZE_W-1:0] axis_idx(input logic [SIZE_W-1:0] q,
                                                   input logic [NW-1:0] n);
        return (q >= SIZE_W'(n)) ? SIZE_W'(n) - SIZE_W'(1) : q;
    endfunction

    t_state                   r_state;
    logic [AW-1:0]            r_clr_addr;

    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic [SIZE_W-1:0]        r_cell_w;
    logic [SIZE_W-1:0]        r_cell_h;
    logic [USE_W-1:0]         r_cols_use;
    logic [USE_W-1:0]         r_rows_use;

    t_kind                    r_kind;
    logic [AW-1:0]            r_addr;
    logic                     r_inside;
    logic [IDX_W-1:0]         r_col;
    logic [IDX_W-1:0]         r_row;
    logic [COUNT_BITS-1:0]    r_obj;
    logic [COUNT_BITS-1:0]    r_csmp;
    logic [COUNT_BITS-1:0]    r_smp;
    logic [COUNT_BITS-1:0]    r_glob;

    logic                     r_out_valid;
    logic                     r_o_inside;
    logic [IDX_W-1:0]         r_o_col;
    logic [IDX_W-1:0]         r_o_row;
    logic [OUT_W-1:0]         r_o_obj;
    logic [OUT_W-1:0]         r_o_smp;

    logic                     in_acc;
    logic                     out_acc;
    logic                     out_free;
    logic                     emit;
    t_kind                    in_kind;
    logic                     cfg_acc;
    logic [NW-1:0]            ncol;
    logic [NW-1:0]            nrow;
    logic                     rd_ok;
    logic [AW-1:0]            rd_addr;
    logic                     div_start;
    logic [DIFF_W-1:0]        diff_x;
    logic [DIFF_W-1:0]        diff_y;
    logic [SIZE_W-1:0]        size_x;
    logic [SIZE_W-1:0]        size_y;
    logic                     done_x;
    logic                     done_y;
    t_div_res                 res_x;
    t_div_res                 res_y;
    logic                     pt_in;
    logic [SIZE_W-1:0]        qx;
    logic [SIZE_W-1:0]        qy;
    logic [AW-1:0]            pt_addr;
    logic [COUNT_BITS-1:0]    obj_rd;
    logic [COUNT_BITS-1:0]    smp_rd;
    logic [COUNT_BITS-1:0]    n_obj;
    logic [COUNT_BITS-1:0]    n_csmp;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [COUNT_BITS-1:0]    obj_wdata;
    logic [COUNT_BITS-1:0]    smp_wdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_kind     = t_kind'(i_kind);
    assign out_acc     = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = (r_state == S_EMIT) && out_free;

    assign ncol    = clamp_n(r_cols_use, NCOL_MAX);
    assign nrow    = clamp_n(r_rows_use, NROW_MAX);
    assign rd_ok   = (NW'(i_read_column) < ncol) && (NW'(i_read_row) < nrow);
    assign rd_addr = cell_addr(COL_W'(i_read_column), ROW_W'(i_read_row));

    assign div_start = in_acc && (in_kind == KIND_ADD || in_kind == KIND_SAMPLE_PT);
    assign diff_x    = {i_point_x[COORD_W-1], i_point_x} - {r_origin_x[COORD_W-1], r_origin_x};
    assign diff_y    = {i_point_y[COORD_W-1], i_point_y} - {r_origin_y[COORD_W-1], r_origin_y};
    assign size_x    = (r_cell_w == '0) ? SIZE_W'(1) : r_cell_w;
    assign size_y    = (r_cell_h == '0) ? SIZE_W'(1) : r_cell_h;

    gcoh_div u_div_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_diff    (diff_x),
        .i_divisor (size_x),
        .o_done    (done_x),
        .o_res     (res_x)
    );

    gcoh_div u_div_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_diff    (diff_y),
        .i_divisor (size_y),
        .o_done    (done_y),
        .o_res     (res_y)
    );

    assign pt_in   = axis_in(res_x, ncol) && axis_in(res_y, nrow);
    assign qx      = axis_idx(res_x.quot, ncol);
    assign qy      = axis_idx(res_y.quot, nrow);
    assign pt_addr = cell_addr(COL_W'(qx), ROW_W'(qy));

    assign n_obj  = (r_kind == KIND_ADD) ? sat_inc(obj_rd) : obj_rd;
    assign n_csmp = (r_kind == KIND_SAMPLE_PT) ? sat_inc(smp_rd) : smp_rd;

    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_RMW && r_kind != KIND_READ);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign obj_wdata = (r_state == S_CLEAR) ? '0 : n_obj;
    assign smp_wdata = (r_state == S_CLEAR) ? '0 : n_csmp;

    gcoh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (obj_wdata),
        .i_raddr (r_addr),
        .o_rdata (obj_rd)
    );

    gcoh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (smp_wdata),
        .i_raddr (r_addr),
        .o_rdata (smp_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_glob      <= '0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_cell_w    <= SIZE_W'(1);
            r_cell_h    <= SIZE_W'(1);
            r_cols_use  <= USE_W'(64);
            r_rows_use  <= USE_W'(64);
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_ORIGIN_X:    r_origin_x <= i_cfg_data;
                    CFG_ORIGIN_Y:    r_origin_y <= i_cfg_data;
                    CFG_CELL_WIDTH:  r_cell_w   <= i_cfg_data;
                    CFG_CELL_HEIGHT: r_cell_h   <= i_cfg_data;
                    CFG_COLUMNS:     r_cols_use <= i_cfg_data[USE_W-1:0];
                    CFG_ROWS:        r_rows_use <= i_cfg_data[USE_W-1:0];
                    default: ;
                endcase
            end

            if (out_acc && !emit) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind <= in_kind;
                        unique case (in_kind) inside
                            KIND_ADD, KIND_SAMPLE_PT: begin
                                r_state <= S_DIV;
                            end
                            KIND_SAMPLE_ALL: begin
                                r_glob   <= sat_inc(r_glob);
                                r_inside <= 1'b1;
                                r_col    <= '0;
                                r_row    <= '0;
                                r_obj    <= '0;
                                r_smp    <= sat_inc(r_glob);
                                r_state  <= S_EMIT;
                            end
                            KIND_READ: begin
                                r_col <= i_read_column;
                                r_row <= i_read_row;
                                if (rd_ok) begin
                                    r_inside <= 1'b1;
                                    r_addr   <= rd_addr;
                                    r_state  <= S_RD;
                                end else begin
                                    r_inside <= 1'b0;
                                    r_obj    <= '0;
                                    r_smp    <= '0;
                                    r_state  <= S_EMIT;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIV: begin
                    if (done_x) begin
                        if (pt_in) begin
                            r_inside <= 1'b1;
                            r_col    <= IDX_W'(qx);
                            r_row    <= IDX_W'(qy);
                            r_addr   <= pt_addr;
                            r_state  <= S_RD;
                        end else begin
                            r_inside <= 1'b0;
                            r_col    <= '0;
                            r_row    <= '0;
                            r_obj    <= '0;
                            r_smp    <= '0;
                            r_state  <= S_EMIT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_RMW;
                end
                S_RMW: begin
                    r_obj   <= n_obj;
                    r_csmp  <= n_csmp;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_smp   <= sat_add(r_csmp, r_glob);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_inside  <= r_inside;
                        r_o_col     <= r_col;
                        r_o_row     <= r_row;
                        r_o_obj     <= OUT_W'(r_obj);
                        r_o_smp     <= OUT_W'(r_smp);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_inside_res   = r_o_inside;
    assign o_cell_column  = r_o_col;
    assign o_cell_row     = r_o_row;
    assign o_object_total = r_o_obj;
    assign o_sample_total = r_o_smp;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("block idle right after taking a beat");

    a_glob_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_kind == KIND_SAMPLE_ALL |=> r_glob >= $past(r_glob))
        else $error("shared sample count went backwards");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_o_inside |-> r_o_obj == '0 && r_o_smp == '0)
        else $error("dropped beat carries nonzero counts");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> done_x == done_y)
        else $error("axis dividers out of step");

endmodule

FILE: verif/gcoh_bin_checker.sv
// Checker for the grid cell occupancy histogram: predicts each result beat and compares it.
`timescale 1ns / 100ps

module gcoh_bin_checker
    import gcoh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic [IDX_W-1:0]          i_read_column,
    input  logic [IDX_W-1:0]          i_read_row,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_inside_res,
    input  logic [IDX_W-1:0]          i_cell_column,
    input  logic [IDX_W-1:0]          i_cell_row,
    input  logic [OUT_W-1:0]          i_object_total,
    input  logic [OUT_W-1:0]          i_sample_total,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int SLOTS       = MAX_COLUMNS * MAX_ROWS;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
        logic [OUT_W-1:0] objects;
        logic [OUT_W-1:0] samples;
    } t_cell_result;

    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [SIZE_W-1:0]         cell_width;
    logic [SIZE_W-1:0]         cell_height;
    logic [USE_W-1:0]          columns_used;
    logic [USE_W-1:0]          rows_used;

    logic [OUT_W-1:0] object_count [SLOTS];
    logic [OUT_W-1:0] cell_samples [SLOTS];
    logic [OUT_W-1:0] shared_samples;

    t_cell_result pending_cells [$];
    t_cell_result want;
    int           mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] exp_val);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + OUT_W'(1);
    endfunction

    function automatic int used_count(input logic [USE_W-1:0] v, input int limit);
        if (v == 0) return 1;
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    function automatic logic [OUT_W-1:0] samples_of(input int slot);
        logic [OUT_W:0] sum;
        sum = {1'b0, cell_samples[slot]} + {1'b0, shared_samples};
        return sum[OUT_W] ? '1 : sum[OUT_W-1:0];
    endfunction

    // Bin one coordinate; zero return means outside the grid.
    function automatic logic locate_axis(input logic signed [COORD_W-1:0] p,
                                         input logic signed [COORD_W-1:0] org,
                                         input logic [SIZE_W-1:0] size, input int n,
                                         output logic [IDX_W-1:0] idx);
        longint d;
        longint s;
        longint q;
        d   = longint'(p) - longint'(org);
        s   = (size == 0) ? 1 : longint'(size);
        idx = '0;
        if (d < 0 || d > s * n) return 1'b0;
        q = d / s;
        if (q >= n) q = n - 1;
        idx = q[IDX_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_cell_result bin_command(input logic [KIND_W-1:0] kind_bits,
                                                 input logic signed [COORD_W-1:0] px,
                                                 input logic signed [COORD_W-1:0] py,
                                                 input logic [IDX_W-1:0] rc,
                                                 input logic [IDX_W-1:0] rr);
        t_cell_result     r;
        int               ncol;
        int               nrow;
        int               slot;
        logic [IDX_W-1:0] cx;
        logic [IDX_W-1:0] ry;
        ncol = used_count(columns_used, MAX_COLUMNS);
        nrow = used_count(rows_used, MAX_ROWS);
        r    = '0;
        case (t_kind'(kind_bits))
            KIND_SAMPLE_ALL: begin
                shared_samples = bump(shared_samples);
                r.hit     = 1'b1;
                r.samples = shared_samples;
            end
            KIND_READ: begin
                r.column = rc;
                r.row    = rr;
                if (int'(rc) < ncol && int'(rr) < nrow) begin
                    slot      = int'(rc) * MAX_ROWS + int'(rr);
                    r.hit     = 1'b1;
                    r.objects = object_count[slot];
                    r.samples = samples_of(slot);
                end
            end
            default: begin
                if (locate_axis(px, origin_x, cell_width, ncol, cx) &&
                    locate_axis(py, origin_y, cell_height, nrow, ry)) begin
                    slot = int'(cx) * MAX_ROWS + int'(ry);
                    if (t_kind'(kind_bits) == KIND_ADD) begin
                        object_count[slot] = bump(object_count[slot]);
                    end else begin
                        cell_samples[slot] = bump(cell_samples[slot]);
                    end
                    r.hit     = 1'b1;
                    r.column  = cx;
                    r.row     = ry;
                    r.objects = object_count[slot];
                    r.samples = samples_of(slot);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            origin_x       = '0;
            origin_y       = '0;
            cell_width     = SIZE_W'(1);
            cell_height    = SIZE_W'(1);
            columns_used   = USE_W'(64);
            rows_used      = USE_W'(64);
            shared_samples = '0;
            for (int k = 0; k < SLOTS; k++) begin
                object_count[k] = '0;
                cell_samples[k] = '0;
            end
            pending_cells.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ORIGIN_X:    origin_x     = i_cfg_data;
                    CFG_ORIGIN_Y:    origin_y     = i_cfg_data;
                    CFG_CELL_WIDTH:  cell_width   = i_cfg_data;
                    CFG_CELL_HEIGHT: cell_height  = i_cfg_data;
                    CFG_COLUMNS:     columns_used = i_cfg_data[USE_W-1:0];
                    CFG_ROWS:        rows_used    = i_cfg_data[USE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_cells.size() == 0) begin
                    report_mismatch("result beat with nothing pending", '0, '0);
                end else begin
                    want = pending_cells.pop_front();
                    if (i_inside_res !== want.hit)
                        report_mismatch("inside_res", OUT_W'(i_inside_res), OUT_W'(want.hit));
                    if (i_cell_column !== want.column)
                        report_mismatch("cell_column", OUT_W'(i_cell_column),
                                        OUT_W'(want.column));
                    if (i_cell_row !== want.row)
                        report_mismatch("cell_row", OUT_W'(i_cell_row), OUT_W'(want.row));
                    if (i_object_total !== want.objects)
                        report_mismatch("object_total", i_object_total, want.objects);
                    if (i_sample_total !== want.samples)
                        report_mismatch("sample_total", i_sample_total, want.samples);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_cells.insert(pending_cells.size(),
                                     bin_command(i_kind, i_point_x, i_point_y,
                                                 i_read_column, i_read_row));
            end
            o_pending <= pending_cells.size();
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the grid cell occupancy histogram: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;
    import gcoh_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 140;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [KIND_W-1:0]         i_kind;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic [IDX_W-1:0]          i_read_column;
    logic [IDX_W-1:0]          i_read_row;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_inside_res;
    logic [IDX_W-1:0]          o_cell_column;
    logic [IDX_W-1:0]          o_cell_row;
    logic [OUT_W-1:0]          o_object_total;
    logic [OUT_W-1:0]          o_sample_total;

    int fail_count;
    int pending;
    int cycles = 0;
    bit quiet_in  = 1'b0;
    bit quiet_out = 1'b0;

    int g_ox;
    int g_oy;
    int g_w;
    int g_h;
    int g_nc;
    int g_nr;

    grid_cell_occupancy_histogram_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_read_column  (i_read_column),
        .i_read_row     (i_read_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .o_cell_column  (o_cell_column),
        .o_cell_row     (o_cell_row),
        .o_object_total (o_object_total),
        .o_sample_total (o_sample_total)
    );

    gcoh_bin_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_read_column  (i_read_column),
        .i_read_row     (i_read_row),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_inside_res   (o_inside_res),
        .i_cell_column  (o_cell_column),
        .i_cell_row     (o_cell_row),
        .i_object_total (o_object_total),
        .i_sample_total (o_sample_total),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[grid_cell_occupancy_histogram_top] ERROR");
            $finish;
        end
    end

    // Receiver: randomly stall before each result beat, unless quiet_out is set.
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = quiet_out ? 0 : $urandom_range(0, 14);
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_beat(input t_kind kind, input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] py, input logic [IDX_W-1:0] rc,
                             input logic [IDX_W-1:0] rr);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_point_x     <= px;
        i_point_y     <= py;
        i_read_column <= rc;
        i_read_row    <= rr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic int clamp_used(input logic [CFG_DATA_W-1:0] v);
        if (v[USE_W-1:0] == 0) return 1;
        return (v[USE_W-1:0] > 64) ? 64 : int'(v[USE_W-1:0]);
    endfunction

    task automatic set_grid(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] nc, input logic [15:0] nr,
                            input bit with_spares);
        drain();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_CELL_WIDTH, w);
        write_reg(CFG_CELL_HEIGHT, h);
        write_reg(CFG_COLUMNS, nc);
        write_reg(CFG_ROWS, nr);
        if (with_spares) begin
            write_reg(CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
            write_reg(CFG_SPARE_HI, 16'($urandom_range(0, 65535)));
        end
        i_cfg_valid <= 1'b0;
        g_ox = int'($signed(ox));
        g_oy = int'($signed(oy));
        g_w  = (w == 0) ? 1 : int'(w);
        g_h  = (h == 0) ? 1 : int'(h);
        g_nc = clamp_used(nc);
        g_nr = clamp_used(nr);
    endtask

    // Mostly points inside the grid, some on and past its edges, some anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(input int org, input int size,
                                                      input int n);
        longint v;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            v = longint'(org) + longint'($urandom_range(0, n - 1)) * longint'(size)
                + longint'($urandom_range(0, size - 1));
        end else if (r < 82) begin
            v = longint'(org) + longint'(n) * longint'(size);
        end else if (r < 88) begin
            v = r[0] ? longint'(org) - 1 : longint'(org) + longint'(n) * longint'(size) + 1;
        end else begin
            v = longint'($urandom_range(0, 65535)) - 32768;
        end
        if (v < -32768 || v > 32767) v = longint'($urandom_range(0, 65535)) - 32768;
        return v[COORD_W-1:0];
    endfunction

    task automatic random_beat();
        int r;
        logic [IDX_W-1:0] rc;
        logic [IDX_W-1:0] rr;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 4) != 0) begin
            rc = IDX_W'($urandom_range(0, g_nc - 1));
            rr = IDX_W'($urandom_range(0, g_nr - 1));
        end else begin
            rc = IDX_W'($urandom_range(0, 63));
            rr = IDX_W'($urandom_range(0, 63));
        end
        if (r < 40)
            send_beat(KIND_ADD, pick_coord(g_ox, g_w, g_nc), pick_coord(g_oy, g_h, g_nr),
                      rc, rr);
        else if (r < 65)
            send_beat(KIND_SAMPLE_PT, pick_coord(g_ox, g_w, g_nc),
                      pick_coord(g_oy, g_h, g_nr), rc, rr);
        else if (r < 75)
            send_beat(KIND_SAMPLE_ALL, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), rc, rr);
        else
            send_beat(KIND_READ, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), rc, rr);
    endtask

    task automatic random_usable_grid();
        set_grid(16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 4000) - 2000),
                 16'($urandom_range(1, 300)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)), 1'b0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ORIGIN_X;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_ADD;
        i_point_x     = '0;
        i_point_y     = '0;
        i_read_column = '0;
        i_read_row    = '0;
        g_ox = 0;
        g_oy = 0;
        g_w  = 1;
        g_h  = 1;
        g_nc = 64;
        g_nr = 64;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset grid: unit cells from the origin, 64 by 64
        send_beat(KIND_ADD, 16'sd0, 16'sd0, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'sd64, 16'sd64, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'sd63, 16'sd63, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'sd65, 16'sd0, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'sd0, -16'sd1, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'h8000, 16'h7FFF, 6'd63, 6'd63);
        send_beat(KIND_ADD, 16'h7FFF, 16'h8000, 6'd63, 6'd63);
        send_beat(KIND_SAMPLE_ALL, 16'h7FFF, 16'h7FFF, 6'd63, 6'd63);
        send_beat(KIND_SAMPLE_PT, 16'sd0, 16'sd0, 6'd0, 6'd0);
        send_beat(KIND_SAMPLE_PT, 16'sd64, 16'sd0, 6'd0, 6'd0);
        send_beat(KIND_READ, 16'sd0, 16'sd0, 6'd0, 6'd0);
        send_beat(KIND_READ, 16'sd0, 16'sd0, 6'd63, 6'd63);
        send_beat(KIND_READ, 16'sd0, 16'sd0, 6'd63, 6'd0);

        // zero cell size and column count, row count above the maximum
        set_grid(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd127, 1'b0);
        send_beat(KIND_ADD, 16'h8000, 16'h7FFF, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'h8001, 16'h7FFF, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'h8002, 16'h7FFF, 6'd0, 6'd0);
        send_beat(KIND_SAMPLE_PT, 16'h8000, 16'h7FFF, 6'd0, 6'd0);
        send_beat(KIND_READ, 16'sd0, 16'sd0, 6'd1, 6'd0);
        send_beat(KIND_READ, 16'sd0, 16'sd0, 6'd0, 6'd63);
        send_beat(KIND_READ, 16'sd0, 16'sd0, 6'd0, 6'd0);

        // widest cells from the lowest origin
        set_grid(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'd64, 16'd64, 1'b0);
        send_beat(KIND_ADD, 16'h7FFF, 16'h7FFF, 6'd0, 6'd0);
        send_beat(KIND_ADD, 16'h8000, 16'h8000, 6'd0, 6'd0);
        send_beat(KIND_READ, 16'sd0, 16'sd0, 6'd1, 6'd1);
        send_beat(KIND_SAMPLE_ALL, 16'sd0, 16'sd0, 6'd0, 6'd0);

        for (int p = 0; p < PHASES; p++) begin
            quiet_in  = (p % 3 == 1) || (p == 4);
            quiet_out = (p % 3 == 2) || (p == 4);
            case (p)
                0: set_grid(16'd0, 16'd0, 16'd1, 16'd1, 16'd8, 16'd8, 1'b0);
                1: set_grid(-16'sd100, 16'sd50, 16'd3, 16'd7, 16'd64, 16'd64, 1'b0);
                3, 7: set_grid(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               1'b1);
                5: set_grid(16'd0, 16'd0, 16'd2, 16'd2, 16'd3, 16'd5, 1'b0);
                6: set_grid(16'd0, 16'd0, 16'd2, 16'd2, 16'd64, 16'd64, 1'b0);
                8: set_grid(16'h8000, 16'h8000, 16'd1024, 16'd1024, 16'd64, 16'd64, 1'b0);
                9: set_grid(16'd10, -16'sd10, 16'd5, 16'd1, 16'd1, 16'd64, 1'b0);
                default: random_usable_grid();
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ((p == 1 && n == 70) || $urandom_range(0, 149) == 0) drain();
                random_beat();
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[grid_cell_occupancy_histogram_top] OK");
        end else begin
            $display("[grid_cell_occupancy_histogram_top] ERROR");
        end
        $finish;
    end

endmodule
